>>> rtl/core/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int unsigned SEC_W       = 32;
   localparam int unsigned MS_W        = 10;
   localparam int unsigned MS_PER_SEC  = 1000;
   localparam int unsigned MS_MAX      = 999;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned FIRED_W     = 5;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SCHED_ABS = 2'd1,
      OP_SCHED_DLY = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_PAST  = 2'd1,
      ST_FULL  = 2'd2,
      ST_FIRED = 2'd3
   } status_type;

   typedef struct packed {
      logic              done;
      logic [SEC_W-1:0]  quotient;
      logic [MS_W-1:0]   remainder;
   } div_status_type;

endpackage

>>> rtl/core/dtq_div1000.sv
// Divider of a 32-bit value by 1000 through a reciprocal multiply.
`timescale 1ns / 1ps

module dtq_div1000 import dtq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SEC_W-1:0] dividend,
   output div_status_type   status
);

   localparam int unsigned RECIP_W = 29;
   localparam int unsigned PROD_W  = SEC_W + RECIP_W;
   localparam int unsigned SHIFT   = 38;
   // ceil(2^38 / 1000); the quotient is exact for every 32-bit dividend
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(274877907);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SEC_W-1:0]  num_ff, num_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SEC_W-1:0]  quo_ff, quo_in;
   logic [MS_W-1:0]   rem_ff, rem_in;
   logic [SEC_W-1:0]  rem_full;

   always_comb begin
      busy_in  = start;
      done_in  = busy_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      rem_full = '0;
      if (start) begin
         // first step: hold the dividend and its scaled product
         num_in  = dividend;
         prod_in = PROD_W'(dividend) * PROD_W'(RECIP);
      end
      if (busy_ff) begin
         // second step: take the quotient, subtract back for the remainder
         quo_in   = SEC_W'(prod_ff[PROD_W-1:SHIFT]);
         rem_full = num_ff - quo_in * SEC_W'(MS_PER_SEC);
         rem_in   = rem_full[MS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

>>> rtl/core/dtq_entry_ram.sv
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module dtq_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 50
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/deadline_timer_queue_core.sv
// Top level of the deadline timer queue: control, clock and result register.
`timescale 1ns / 1ps
//
// Usage:
//   Requests come on the req_ channel (valid/ready); each beat carries an
//   operation: tick, schedule absolute, schedule after delay, or clear.
//   Results leave on the rsp_ channel (valid/ready). Every request makes at
//   least one result beat; the final one of a request has rsp_last high.
//   A tick makes one beat per task that came due (status fired, at most 16),
//   or a single accepted beat when nothing is due.
//   One request is worked at a time; req_ready is high only while idle.
//   Work per request: clear goes straight to the result; a schedule
//   compares entries of the sorted store from its tail; schedule after
//   delay first runs the divide by 1000 (reciprocal multiply); a tick
//   reads due entries from the head. The entry RAM has one read and one
//   write port and is walked one entry per read-then-write pair.
//   Entries live in a circular RAM addressed from a head pointer, so
//   firing just advances the head.
//   Reset clears the clock, the entry count, the head and the result valid;
//   the RAM contents are left as they are. When the receiver stalls, the
//   result register holds its beat and the walk waits in place.
//
module deadline_timer_queue_core import dtq_pkg::*; #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_operation,
   input  logic [TASK_ID_BITS-1:0] req_task_id,
   input  logic [SEC_W-1:0]        req_due_seconds,
   input  logic [MS_W-1:0]         req_due_millis,
   input  logic [SEC_W-1:0]        req_delay_millis,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [TASK_ID_BITS-1:0] rsp_fired_task,
   output logic                    rsp_last
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int KEY_W = SEC_W + MS_W;
   localparam int ENT_W = KEY_W + TASK_ID_BITS;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_DIV     = 9'b000000010,
      S_INS_CHK = 9'b000000100,
      S_INS_RD  = 9'b000001000,
      S_INS_CMP = 9'b000010000,
      S_INS_PUT = 9'b000100000,
      S_TK_RD   = 9'b001000000,
      S_TK_CMP  = 9'b010000000,
      S_FINISH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [SEC_W-1:0]        clk_s_ff, clk_s_in;
   logic [MS_W-1:0]         clk_ms_ff, clk_ms_in;
   logic [CNT_W-1:0]        walk_ff, walk_in;
   logic [FIRED_W-1:0]      fired_ff, fired_in;
   logic                    pend_ff, pend_in;
   logic [TASK_ID_BITS-1:0] pend_task_ff, pend_task_in;
   logic [SEC_W-1:0]        ins_s_ff, ins_s_in;
   logic [MS_W-1:0]         ins_ms_ff, ins_ms_in;
   logic [TASK_ID_BITS-1:0] ins_task_ff, ins_task_in;
   status_type              fin_st_ff, fin_st_in;
   logic [TASK_ID_BITS-1:0] fin_task_ff, fin_task_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_st_ff, rsp_st_in;
   logic [TASK_ID_BITS-1:0] rsp_task_ff, rsp_task_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    slot_free;
   logic                    accept;
   logic                    div_start;
   div_status_type          div_st;
   logic                    wr_en, rd_en;
   logic [IDX_W-1:0]        wr_addr, rd_addr;
   logic [ENT_W-1:0]        wr_data, rd_data;
   logic [KEY_W-1:0]        rd_key, ins_key, now_key;
   logic [MS_W:0]           ms_sum;
   logic                    ms_carry;
   logic [MS_W-1:0]         due_ms_sat;

   // logical queue position to RAM slot
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(pos);
      if (s >= SUM_W'(QUEUE_DEPTH)) begin
         s = s - SUM_W'(QUEUE_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   dtq_div1000 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_delay_millis),
      .status   (div_st)
   );

   dtq_entry_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign div_start  = accept && (op_type'(req_operation) == OP_SCHED_DLY);
   assign rd_key     = rd_data[ENT_W-1:TASK_ID_BITS];
   assign ins_key    = {ins_s_ff, ins_ms_ff};
   assign now_key    = {clk_s_ff, clk_ms_ff};
   assign due_ms_sat = (req_due_millis > MS_W'(MS_MAX)) ? MS_W'(MS_MAX) : req_due_millis;
   assign ms_sum     = (MS_W+1)'(clk_ms_ff) + (MS_W+1)'(div_st.remainder);
   assign ms_carry   = ms_sum >= (MS_W+1)'(MS_PER_SEC);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      clk_s_in     = clk_s_ff;
      clk_ms_in    = clk_ms_ff;
      walk_in      = walk_ff;
      fired_in     = fired_ff;
      pend_in      = pend_ff;
      pend_task_in = pend_task_ff;
      ins_s_in     = ins_s_ff;
      ins_ms_in    = ins_ms_ff;
      ins_task_in  = ins_task_ff;
      fin_st_in    = fin_st_ff;
      fin_task_in  = fin_task_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_st_in    = rsp_st_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, walk_ff);
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ins_task_in = req_task_id;
               ins_s_in    = req_due_seconds;
               ins_ms_in   = due_ms_sat;
               fin_task_in = '0;
               unique case (op_type'(req_operation))
                  OP_TICK: begin
                     // advance the clock, then walk the due entries
                     if (clk_ms_ff == MS_W'(MS_MAX)) begin
                        clk_ms_in = '0;
                        clk_s_in  = clk_s_ff + SEC_W'(1);
                     end else begin
                        clk_ms_in = clk_ms_ff + MS_W'(1);
                     end
                     fired_in = '0;
                     pend_in  = 1'b0;
                     state_in = S_TK_RD;
                  end
                  OP_SCHED_ABS: state_in = S_INS_CHK;
                  OP_SCHED_DLY: state_in = S_DIV;
                  OP_CLEAR: begin
                     count_in  = '0;
                     fin_st_in = ST_OK;
                     state_in  = S_FINISH;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            if (div_st.done) begin
               ins_ms_in = ms_carry ? MS_W'(ms_sum - (MS_W+1)'(MS_PER_SEC)) : ms_sum[MS_W-1:0];
               ins_s_in  = clk_s_ff + div_st.quotient + SEC_W'(ms_carry);
               state_in  = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (ins_key < now_key) begin
               fin_st_in = ST_PAST;
               state_in  = S_FINISH;
            end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
               fin_st_in = ST_FULL;
               state_in  = S_FINISH;
            end else begin
               walk_in  = count_ff;
               state_in = (count_ff == '0) ? S_INS_PUT : S_INS_RD;
            end
         end
         S_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, walk_ff - CNT_W'(1));
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            // later deadline moves up one slot; equal keys stay ahead
            if (rd_key > ins_key) begin
               wr_en    = 1'b1;
               walk_in  = walk_ff - CNT_W'(1);
               state_in = (walk_ff == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            wr_en     = 1'b1;
            wr_data   = {ins_s_ff, ins_ms_ff, ins_task_ff};
            count_in  = count_ff + CNT_W'(1);
            fin_st_in = ST_OK;
            state_in  = S_FINISH;
         end
         S_TK_RD: begin
            if (count_ff != '0 && fired_ff != FIRED_W'(MAX_RESULTS)) begin
               rd_en    = 1'b1;
               state_in = S_TK_CMP;
            end else begin
               fin_st_in   = pend_ff ? ST_FIRED : ST_OK;
               fin_task_in = pend_ff ? pend_task_ff : '0;
               state_in    = S_FINISH;
            end
         end
         S_TK_CMP: begin
            if (rd_key <= now_key) begin
               // hold the due entry until the earlier one has gone out
               if (!pend_ff || slot_free) begin
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_st_in    = ST_FIRED;
                     rsp_task_in  = pend_task_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_task_in = rd_data[TASK_ID_BITS-1:0];
                  head_in      = slot_of(head_ff, CNT_W'(1));
                  count_in     = count_ff - CNT_W'(1);
                  fired_in     = fired_ff + FIRED_W'(1);
                  state_in     = S_TK_RD;
               end
            end else begin
               fin_st_in   = pend_ff ? ST_FIRED : ST_OK;
               fin_task_in = pend_ff ? pend_task_ff : '0;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = fin_st_ff;
               rsp_task_in  = fin_task_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         clk_s_ff     <= '0;
         clk_ms_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         clk_s_ff     <= clk_s_in;
         clk_ms_ff    <= clk_ms_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff      <= walk_in;
      fired_ff     <= fired_in;
      pend_task_ff <= pend_task_in;
      ins_s_ff     <= ins_s_in;
      ins_ms_ff    <= ins_ms_in;
      ins_task_ff  <= ins_task_in;
      fin_st_ff    <= fin_st_in;
      fin_task_ff  <= fin_task_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_fired_task = rsp_task_ff;
   assign rsp_last       = rsp_last_ff;

   // queue never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above depth");

   // only fired beats carry a task id
   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FIRED |-> rsp_fired_task == '0)
      else $error("task id on a non-fired beat");

   // a fired beat without last is always followed by more of the same tick
   a_fire_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_FIRED && !req_ready)
      else $error("open fired run while idle");

   // the clock milliseconds never reach 1000
   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      clk_ms_ff <= MS_W'(MS_MAX))
      else $error("clock millis out of range");

endmodule
